### rtl/hkr_pkg.sv
package hkr_pkg;

   // report geometry
   localparam int KEY_SLOTS  = 6;
   localparam int SLOT_ARRAY = 6;
   localparam int SLOT_IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int CNT_W      = $clog2(2 * KEY_SLOTS);
   localparam int NEXT_W     = $clog2(KEY_SLOTS + 1);

   // modifier keycode range
   localparam logic [7:0] MOD_FIRST = 8'hE0;
   localparam logic [7:0] MOD_LAST  = 8'hE7;
   localparam logic [7:0] MOD_ONE   = 8'h01;

   // result word layout: four flag bits plus mods, slots and sent mods
   localparam int RSP_BITS   = 4 + 8 * (SLOT_ARRAY + 2);
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // item kinds
   typedef enum logic [1:0] {
      KIND_PRESS       = 2'd0,
      KIND_RELEASE     = 2'd1,
      KIND_RELEASE_ALL = 2'd2,
      KIND_SEND        = 2'd3
   } kind_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_APPLY = 5'b00100,
      S_QUERY = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // shared compare unit result
   typedef struct packed {
      logic eq;
      logic a_zero;
   } cmp_res_type;

endpackage

### rtl/hid_boot_key_report_builder_top.sv
// boot keyboard report builder, six-key rollover
//
// input words arrive on req_: req_tuser carries the kind (press, release,
// release all, send if changed) and req_tdata the keycode. each word gives
// exactly one result word on rsp_: accept and send flags, the current
// modifier byte and key slots, the down flags for the keycode in the current
// and the last sent report, and the sent modifier byte.
//
// each word runs a pass over the slots for the update, an apply step,
// then two passes (current, then sent report) for the key query.
// every pass goes through the single byte comparator, one slot a cycle.
// req_tready is high only while the sequencer is idle, so one word is in
// flight at a time; the next word can be taken in the cycle after the
// result is taken.
//
// synchronous reset clears both reports and returns the sequencer to idle.
// a stalled rsp_tready holds the result word steady and keeps req_tready low.
module hid_boot_key_report_builder_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // keycode[7:0]
   input  logic [1:0]                     req_tuser,   // kind[1:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // accepted[0], report_sent[1], modifier_bits[9:2], slot_zero[17:10],
   // slot_one[25:18], slot_two[33:26], slot_three[41:34], slot_four[49:42],
   // slot_five[57:50], key_is_down[58], key_was_down[59],
   // sent_modifier_bits[67:60], zero fill above
   output logic [hkr_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int N = hkr_pkg::KEY_SLOTS;

   hkr_pkg::state_type            state_ff, state_in;
   hkr_pkg::kind_type             kind_ff, kind_in;
   logic [7:0]                    key_ff, key_in;
   logic [hkr_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [hkr_pkg::NEXT_W-1:0]    next_ff, next_in;
   logic [hkr_pkg::SLOT_IDX_W-1:0] empty_ff, empty_in;
   logic                          found_ff, found_in;
   logic                          has_empty_ff, has_empty_in;
   logic                          diff_ff, diff_in;
   logic                          acc_ff, acc_in;
   logic                          sent_flag_ff, sent_flag_in;
   logic                          is_hit_ff, is_hit_in;
   logic                          was_hit_ff, was_hit_in;

   logic [7:0]                    cur_mods_ff, cur_mods_in;
   logic [7:0]                    sent_mods_ff, sent_mods_in;
   logic [7:0]                    cur_slots_ff  [N];
   logic [7:0]                    cur_slots_in  [N];
   logic [7:0]                    sent_slots_ff [N];
   logic [7:0]                    sent_slots_in [N];

   logic [hkr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared comparator and its operand selection
   logic [7:0]                    op_a, op_b;
   hkr_pkg::cmp_res_type          cmp;
   logic [hkr_pkg::SLOT_IDX_W-1:0] slot_idx;
   logic                          query_sent;
   logic                          is_mod;
   logic [7:0]                    mod_mask;
   logic                          req_fire;
   logic                          rsp_fire;
   logic                          last_scan;
   logic                          last_query;
   logic                          is_down;
   logic                          was_down;

   hkr_cmp_unit u_cmp (
      .op_a (op_a),
      .op_b (op_b),
      .res  (cmp)
   );

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == hkr_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == hkr_pkg::S_DONE);
   assign rsp_tdata  = rsp_data_ff;

   assign is_mod    = (key_ff >= hkr_pkg::MOD_FIRST) && (key_ff <= hkr_pkg::MOD_LAST);
   assign mod_mask  = hkr_pkg::MOD_ONE << key_ff[2:0];
   assign last_scan  = (idx_ff == hkr_pkg::CNT_W'(N - 1));
   assign last_query = (idx_ff == hkr_pkg::CNT_W'(2 * N - 1));

   // second half of the query pass walks the sent report
   assign query_sent = (state_ff == hkr_pkg::S_QUERY) && (idx_ff >= hkr_pkg::CNT_W'(N));

   always_comb begin
      if (query_sent) begin
         slot_idx = hkr_pkg::SLOT_IDX_W'(idx_ff - hkr_pkg::CNT_W'(N));
      end else begin
         slot_idx = hkr_pkg::SLOT_IDX_W'(idx_ff);
      end
   end

   always_comb begin
      op_a = query_sent ? sent_slots_ff[slot_idx] : cur_slots_ff[slot_idx];
      if ((state_ff == hkr_pkg::S_SCAN) && (kind_ff == hkr_pkg::KIND_SEND)) begin
         op_b = sent_slots_ff[slot_idx];
      end else begin
         op_b = key_ff;
      end
   end

   // final down flags: modifiers answer from their bit, keycode zero is never down
   always_comb begin
      if (is_mod) begin
         is_down  = |(cur_mods_ff & mod_mask);
         was_down = |(sent_mods_ff & mod_mask);
      end else begin
         is_down  = (key_ff != 8'h00) && is_hit_ff;
         was_down = (key_ff != 8'h00) && was_hit_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      next_in      = next_ff;
      empty_in     = empty_ff;
      found_in     = found_ff;
      has_empty_in = has_empty_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      sent_flag_in = sent_flag_ff;
      is_hit_in    = is_hit_ff;
      was_hit_in   = was_hit_ff;
      cur_mods_in  = cur_mods_ff;
      sent_mods_in = sent_mods_ff;
      cur_slots_in  = cur_slots_ff;
      sent_slots_in = sent_slots_ff;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         hkr_pkg::S_IDLE: begin
            if (req_fire) begin
               kind_in      = hkr_pkg::kind_type'(req_tuser);
               key_in       = req_tdata;
               idx_in       = '0;
               next_in      = '0;
               empty_in     = '0;
               found_in     = 1'b0;
               has_empty_in = 1'b0;
               diff_in      = 1'b0;
               acc_in       = 1'b1;
               sent_flag_in = 1'b0;
               is_hit_in    = 1'b0;
               was_hit_in   = 1'b0;
               state_in     = hkr_pkg::S_SCAN;
            end
         end

         hkr_pkg::S_SCAN: begin
            unique case (kind_ff)
               hkr_pkg::KIND_PRESS: begin
                  if (cmp.eq) begin
                     found_in = 1'b1;
                  end
                  if (cmp.a_zero && !has_empty_ff) begin
                     has_empty_in = 1'b1;
                     empty_in     = slot_idx;
                  end
               end
               hkr_pkg::KIND_RELEASE: begin
                  // in-place stable compaction, write index never passes read index
                  if (!is_mod && !cmp.a_zero && !cmp.eq) begin
                     cur_slots_in[hkr_pkg::SLOT_IDX_W'(next_ff)] = op_a;
                     next_in = next_ff + 1'b1;
                  end
               end
               hkr_pkg::KIND_SEND: begin
                  if (!cmp.eq) begin
                     diff_in = 1'b1;
                  end
               end
               hkr_pkg::KIND_RELEASE_ALL: begin
               end
               default: begin
               end
            endcase
            if (last_scan) begin
               idx_in   = '0;
               state_in = hkr_pkg::S_APPLY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         hkr_pkg::S_APPLY: begin
            unique case (kind_ff)
               hkr_pkg::KIND_PRESS: begin
                  if (is_mod) begin
                     cur_mods_in = cur_mods_ff | mod_mask;
                  end else if ((key_ff != 8'h00) && !found_ff) begin
                     if (has_empty_ff) begin
                        cur_slots_in[empty_ff] = key_ff;
                     end else begin
                        acc_in = 1'b0;
                     end
                  end
               end
               hkr_pkg::KIND_RELEASE: begin
                  if (is_mod) begin
                     cur_mods_in = cur_mods_ff & ~mod_mask;
                  end else begin
                     for (int j = 0; j < N; j++) begin
                        if (hkr_pkg::NEXT_W'(j) >= next_ff) begin
                           cur_slots_in[j] = 8'h00;
                        end
                     end
                  end
               end
               hkr_pkg::KIND_RELEASE_ALL: begin
                  cur_mods_in = 8'h00;
                  for (int j = 0; j < N; j++) begin
                     cur_slots_in[j] = 8'h00;
                  end
               end
               hkr_pkg::KIND_SEND: begin
                  if (diff_ff || (cur_mods_ff != sent_mods_ff)) begin
                     sent_mods_in  = cur_mods_ff;
                     sent_slots_in = cur_slots_ff;
                     sent_flag_in  = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            state_in = hkr_pkg::S_QUERY;
         end

         hkr_pkg::S_QUERY: begin
            if (cmp.eq) begin
               if (query_sent) begin
                  was_hit_in = 1'b1;
               end else begin
                  is_hit_in = 1'b1;
               end
            end
            if (last_query) begin
               state_in = hkr_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         hkr_pkg::S_DONE: begin
            if (rsp_fire) begin
               state_in = hkr_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = hkr_pkg::S_IDLE;
         end
      endcase

      // result word is built as the last query step retires
      if ((state_ff == hkr_pkg::S_QUERY) && last_query) begin
         rsp_data_in       = '0;
         rsp_data_in[0]    = acc_ff;
         rsp_data_in[1]    = sent_flag_ff;
         rsp_data_in[9:2]  = cur_mods_ff;
         for (int j = 0; j < hkr_pkg::SLOT_ARRAY; j++) begin
            if (j < N) begin
               rsp_data_in[10 + 8 * j +: 8] = cur_slots_ff[j];
            end
         end
         rsp_data_in[10 + 8 * hkr_pkg::SLOT_ARRAY]      = is_down || (cmp.eq && !query_sent
                                                           && !is_mod && (key_ff != 8'h00));
         rsp_data_in[11 + 8 * hkr_pkg::SLOT_ARRAY]      = was_down || (cmp.eq && query_sent
                                                           && !is_mod && (key_ff != 8'h00));
         rsp_data_in[12 + 8 * hkr_pkg::SLOT_ARRAY +: 8] = sent_mods_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hkr_pkg::S_IDLE;
         cur_mods_ff  <= 8'h00;
         sent_mods_ff <= 8'h00;
         for (int j = 0; j < N; j++) begin
            cur_slots_ff[j]  <= 8'h00;
            sent_slots_ff[j] <= 8'h00;
         end
         idx_ff       <= '0;
         next_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cur_mods_ff   <= cur_mods_in;
         sent_mods_ff  <= sent_mods_in;
         cur_slots_ff  <= cur_slots_in;
         sent_slots_ff <= sent_slots_in;
         idx_ff        <= idx_in;
         next_ff       <= next_in;
      end
   end

   // per-word working registers and result payload
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      empty_ff     <= empty_in;
      found_ff     <= found_in;
      has_empty_ff <= has_empty_in;
      diff_ff      <= diff_in;
      acc_ff       <= acc_in;
      sent_flag_ff <= sent_flag_in;
      is_hit_ff    <= is_hit_in;
      was_hit_ff   <= was_hit_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("result pending while input side ready");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == hkr_pkg::S_SCAN) && (idx_ff == '0))
      else $error("accepted word did not start the slot pass");

   a_pack_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= hkr_pkg::NEXT_W'(N))
      else $error("compaction write index past the last slot");

   a_sent_latched: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> (sent_mods_ff == cur_mods_ff))
      else $error("sent report not equal to current after a send");

   a_query_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hkr_pkg::S_QUERY) |-> (idx_ff <= hkr_pkg::CNT_W'(2 * N - 1)))
      else $error("query counter out of range");
`endif

endmodule

### rtl/hkr_cmp_unit.sv
module hkr_cmp_unit (
   input  logic [7:0]          op_a,
   input  logic [7:0]          op_b,
   output hkr_pkg::cmp_res_type res
);

   // byte equality plus empty-slot test on the first operand
   assign res.eq     = (op_a == op_b);
   assign res.a_zero = (op_a == 8'h00);

endmodule

### sim/hid_boot_key_report_builder_top_tb.sv
module hid_boot_key_report_builder_top_tb;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_WORDS  = 530;
   localparam int CALM_TAIL     = 60;    // last random words run with no idling
   localparam int LONG_HOLD     = 200;   // receiver hold-off, in cycles
   localparam int SETTLE_CYCLES = 3 * hkr_pkg::KEY_SLOTS + 10;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int RSP_USED      = 12 + 8 * (hkr_pkg::SLOT_ARRAY + 1);
   localparam int POOL_SIZE     = 9;     // more keys than slots, so the report fills up

   // one input word plus the sender's handling of it
   typedef struct packed {
      hkr_pkg::kind_type kind;
      logic [7:0]        keycode;
      logic              wait_drain;   // sender waits until every result is back
      logic              calm;         // no idling on either side
   } key_word_type;

   // expected result word
   typedef struct packed {
      logic                                accepted;
      logic                                report_sent;
      logic [7:0]                          mods;
      logic [hkr_pkg::SLOT_ARRAY-1:0][7:0] slots;
      logic                                is_down;
      logic                                was_down;
      logic [7:0]                          sent_mods;
   } key_report_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = 8'd0;
   logic [1:0]                     req_tuser = 2'd0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [hkr_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // predictor state: the live report and the last latched one
   logic [7:0]                          now_mods = 8'd0;
   logic [7:0]                          latched_mods = 8'd0;
   logic [hkr_pkg::SLOT_ARRAY-1:0][7:0] now_slots = '0;
   logic [hkr_pkg::SLOT_ARRAY-1:0][7:0] latched_slots = '0;

   key_word_type   pending_words[$];
   key_report_type expected_reports[$];
   logic [7:0]     key_pool[POOL_SIZE];

   int                errors = 0;
   int                total_words = 0;
   int                words_taken = 0;
   int                gap_left = 0;
   int                stall_left = 0;
   int                hold_cycles = 0;
   int                holds_done = 0;
   logic              calm = 1'b0;
   hkr_pkg::kind_type held_kind = hkr_pkg::KIND_PRESS;
   logic [7:0]        held_key = 8'd0;

   hid_boot_key_report_builder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic logic is_mod_key(logic [7:0] k);
      return k >= hkr_pkg::MOD_FIRST && k <= hkr_pkg::MOD_LAST;
   endfunction

   // modifier codes map onto the byte by their low three bits
   function automatic logic [7:0] mod_bit(logic [7:0] k);
      return hkr_pkg::MOD_ONE << k[2:0];
   endfunction

   function automatic logic key_held(logic [7:0] mods,
                                     logic [hkr_pkg::SLOT_ARRAY-1:0][7:0] slots,
                                     logic [7:0] k);
      logic hit;
      hit = 1'b0;
      if (is_mod_key(k)) begin
         hit = |(mods & mod_bit(k));
      end else if (k != 8'd0) begin
         for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++)
            if (slots[i] == k) hit = 1'b1;
      end
      return hit;
   endfunction

   // apply one key event to the predicted report and queue the result word
   task automatic predict_report(hkr_pkg::kind_type kind, logic [7:0] k);
      key_report_type                      r;
      logic                                present;
      logic                                placed;
      logic [hkr_pkg::SLOT_ARRAY-1:0][7:0] kept;
      int                                  fill;
      r = '0;
      r.accepted = 1'b1;
      case (kind)
         hkr_pkg::KIND_PRESS: begin
            if (is_mod_key(k)) begin
               now_mods = now_mods | mod_bit(k);
            end else if (k != 8'd0) begin
               present = 1'b0;
               for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++)
                  if (now_slots[i] == k) present = 1'b1;
               if (!present) begin
                  placed = 1'b0;
                  for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++) begin
                     if (!placed && now_slots[i] == 8'd0) begin
                        now_slots[i] = k;
                        placed = 1'b1;
                     end
                  end
                  r.accepted = placed;   // no free slot rejects the press
               end
            end
         end
         hkr_pkg::KIND_RELEASE: begin
            if (is_mod_key(k)) begin
               now_mods = now_mods & ~mod_bit(k);
            end else begin
               // drop matching keys, close the gaps keeping the order
               kept = '0;
               fill = 0;
               for (int i = 0; i < hkr_pkg::KEY_SLOTS; i++) begin
                  if (now_slots[i] != 8'd0 && now_slots[i] != k) begin
                     kept[fill] = now_slots[i];
                     fill++;
                  end
               end
               now_slots = kept;
            end
         end
         hkr_pkg::KIND_RELEASE_ALL: begin
            now_mods  = 8'd0;
            now_slots = '0;
         end
         hkr_pkg::KIND_SEND: begin
            if (now_mods != latched_mods || now_slots != latched_slots) begin
               latched_mods  = now_mods;
               latched_slots = now_slots;
               r.report_sent = 1'b1;
            end
         end
      endcase
      r.mods      = now_mods;
      r.slots     = now_slots;
      r.is_down   = key_held(now_mods, now_slots, k);
      r.was_down  = key_held(latched_mods, latched_slots, k);
      r.sent_mods = latched_mods;
      expected_reports.push_back(r);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_report(logic [hkr_pkg::RSP_DATA_W-1:0] word);
      key_report_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: result word with nothing outstanding, expected none, actual %h",
                  $time, word);
         errors++;
         return;
      end
      want = expected_reports.pop_front();
      compare_field("accepted", want.accepted, word[0]);
      compare_field("report_sent", want.report_sent, word[1]);
      compare_field("modifier_bits", want.mods, word[9:2]);
      for (int i = 0; i < hkr_pkg::SLOT_ARRAY; i++)
         compare_field($sformatf("slot %0d", i), want.slots[i], word[10 + 8 * i +: 8]);
      compare_field("key_is_down", want.is_down, word[58]);
      compare_field("key_was_down", want.was_down, word[59]);
      compare_field("sent_modifier_bits", want.sent_mods, word[67:60]);
      compare_field("zero fill", '0, word[hkr_pkg::RSP_DATA_W-1:RSP_USED]);
   endtask

   function automatic logic [7:0] pick_keycode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         return hkr_pkg::MOD_FIRST + 8'($urandom_range(0, 7));
      else if (roll < 85)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (roll < 90)
         return 8'd0;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic hkr_pkg::kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return hkr_pkg::KIND_PRESS;
      else if (roll < 75)
         return hkr_pkg::KIND_RELEASE;
      else if (roll < 96)
         return hkr_pkg::KIND_SEND;
      return hkr_pkg::KIND_RELEASE_ALL;
   endfunction

   task automatic queue_word(hkr_pkg::kind_type kind, logic [7:0] k,
                             logic wait_drain = 1'b0, logic quiet = 1'b0);
      key_word_type w;
      w.kind       = kind;
      w.keycode    = k;
      w.wait_drain = wait_drain;
      w.calm       = quiet;
      pending_words.push_back(w);
   endtask

   // sender: offers queued words, idles in bursts, pauses for a drain on request
   always @(posedge clock) begin : drive_words
      logic         took;
      key_word_type w;
      took = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (took) begin
            predict_report(held_kind, held_key);
            words_taken <= words_taken + 1;
         end
         if (req_tvalid && !took) begin
            // word still on offer, hold it
         end else if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() == 0 ||
                      (pending_words[0].wait_drain && expected_reports.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else if (!pending_words[0].calm && $urandom_range(0, 2) == 0) begin
            gap_left = $urandom_range(1, 8) - 1;
            req_tvalid <= 1'b0;
         end else begin
            w = pending_words.pop_front();
            held_kind = w.kind;
            held_key  = w.keycode;
            calm      <= w.calm;
            req_tuser  <= w.kind;
            req_tdata  <= w.keycode;
            req_tvalid <= 1'b1;
         end
      end
   end

   // receiver: checks each result word, stalls in bursts
   always @(posedge clock) begin : take_reports
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_report(rsp_tdata);
         if (stall_left != 0)
            stall_left--;
         else if (!calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
         rsp_tready <= (stall_left == 0) && (hold_cycles == 0);
      end
   end

   // long receiver hold-offs while the sender keeps offering, so the input backs up
   always @(posedge clock) begin : long_hold
      if (reset) begin
         hold_cycles <= 0;
         holds_done  <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if ((holds_done == 0 && words_taken >= 120) ||
                   (holds_done == 1 && words_taken >= 350)) begin
         hold_cycles <= LONG_HOLD;
         holds_done  <= holds_done + 1;
      end
   end

   initial begin : run_stimulus
      logic quiet;
      for (int i = 0; i < POOL_SIZE - 1; i++)
         key_pool[i] = 8'($urandom_range(1, 8'hDF));
      key_pool[POOL_SIZE - 1] = 8'($urandom_range(8'hE8, 8'hFF));

      // directed: empty send, keycode zero, modifier extremes, full report,
      // duplicate press, compaction, absent release, release all
      queue_word(hkr_pkg::KIND_SEND, 8'h00);
      queue_word(hkr_pkg::KIND_PRESS, 8'h00);
      queue_word(hkr_pkg::KIND_RELEASE, 8'h00);
      queue_word(hkr_pkg::KIND_PRESS, hkr_pkg::MOD_FIRST);
      queue_word(hkr_pkg::KIND_PRESS, hkr_pkg::MOD_LAST);
      queue_word(hkr_pkg::KIND_PRESS, 8'hFF);
      queue_word(hkr_pkg::KIND_PRESS, 8'h01);
      queue_word(hkr_pkg::KIND_PRESS, 8'h04);
      queue_word(hkr_pkg::KIND_PRESS, 8'h04);
      queue_word(hkr_pkg::KIND_PRESS, 8'h05);
      queue_word(hkr_pkg::KIND_PRESS, 8'h06);
      queue_word(hkr_pkg::KIND_PRESS, 8'h07);
      queue_word(hkr_pkg::KIND_PRESS, 8'h08);
      queue_word(hkr_pkg::KIND_PRESS, 8'hE3);
      queue_word(hkr_pkg::KIND_SEND, 8'hFF);
      queue_word(hkr_pkg::KIND_SEND, hkr_pkg::MOD_LAST);
      queue_word(hkr_pkg::KIND_RELEASE, 8'h04);
      queue_word(hkr_pkg::KIND_RELEASE, 8'h55);
      queue_word(hkr_pkg::KIND_RELEASE, hkr_pkg::MOD_FIRST);
      queue_word(hkr_pkg::KIND_PRESS, 8'h08);
      queue_word(hkr_pkg::KIND_PRESS, 8'hFF);
      queue_word(hkr_pkg::KIND_RELEASE, 8'hFF);
      queue_word(hkr_pkg::KIND_SEND, 8'h08);
      queue_word(hkr_pkg::KIND_RELEASE_ALL, hkr_pkg::MOD_LAST);
      queue_word(hkr_pkg::KIND_SEND, 8'h01);
      queue_word(hkr_pkg::KIND_RELEASE, hkr_pkg::MOD_LAST);

      // random key traffic over a small key set, with some stray codes
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         quiet = (i >= RANDOM_WORDS - CALM_TAIL);
         queue_word(pick_kind(), pick_keycode(),
                    (i == 200) || ($urandom_range(0, 39) == 0), quiet);
      end
      total_words = pending_words.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      wait (words_taken == total_words);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("FAIL");
      $finish;
   end

endmodule
